// ===== rtl/akf_pkg.sv =====
// ----------------------------------------------------------------------------
// akf_pkg: shared types and constants of the altitude Kalman filter
// Payload structs, micro-op codes, register-file map and the filter program.
// ----------------------------------------------------------------------------
`default_nettype none

package akf_pkg;

  typedef struct packed {
    logic signed [31:0] baro_altitude;
    logic signed [31:0] vertical_accel;
    logic        [23:0] time_step;
  } akf_in_t;

  typedef struct packed {
    logic signed [31:0] altitude_estimate;
    logic signed [31:0] climb_rate;
    logic signed [31:0] accel_bias;
  } akf_out_t;

  // configuration register indexes
  localparam logic [1:0] CFG_BARO_NOISE = 2'd0;
  localparam logic [1:0] CFG_ACCEL_VAR  = 2'd1;
  localparam logic [1:0] CFG_BIAS_VAR   = 2'd2;

  typedef enum logic [3:0] {
    OP_LD, OP_MOV, OP_ADD, OP_SUB, OP_HALF, OP_MUL, OP_RCP, OP_OUT, OP_END, OP_HALT
  } op_t;

  typedef logic [5:0] addr_t;

  typedef struct packed {
    op_t   op;
    logic  seed;   // runs on the first item only
    addr_t dst;
    addr_t a;
    addr_t b;
  } instr_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_WAIT, ST_PUB
  } state_t;

  typedef struct packed {
    instr_t ins;
    logic   issue;
    logic   commit;
    logic   in_load;
  } akf_cmd_t;

  typedef struct packed {
    logic unit_done;
  } akf_stat_t;

  // register file map
  localparam addr_t R_ALT  = 6'd0;
  localparam addr_t R_VEL  = 6'd1;
  localparam addr_t R_BIAS = 6'd2;
  localparam addr_t R_P0   = 6'd3;
  localparam addr_t R_P1   = 6'd4;
  localparam addr_t R_P2   = 6'd5;
  localparam addr_t R_P3   = 6'd6;
  localparam addr_t R_P4   = 6'd7;
  localparam addr_t R_P5   = 6'd8;
  localparam addr_t R_P6   = 6'd9;
  localparam addr_t R_P7   = 6'd10;
  localparam addr_t R_P8   = 6'd11;
  localparam addr_t R_Z    = 6'd12;
  localparam addr_t R_ACC  = 6'd13;
  localparam addr_t R_DT   = 6'd14;
  localparam addr_t R_QA   = 6'd15;
  localparam addr_t R_QB   = 6'd16;
  localparam addr_t R_RB   = 6'd17;
  localparam addr_t R_DT2  = 6'd18;
  localparam addr_t R_DT2H = 6'd19;
  localparam addr_t R_DT3H = 6'd20;
  localparam addr_t R_DT4Q = 6'd21;
  localparam addr_t R_T00  = 6'd22;
  localparam addr_t R_T01  = 6'd23;
  localparam addr_t R_T02  = 6'd24;
  localparam addr_t R_T10  = 6'd25;
  localparam addr_t R_T11  = 6'd26;
  localparam addr_t R_T12  = 6'd27;
  localparam addr_t R_X1   = 6'd28;
  localparam addr_t R_INNO = 6'd29;
  localparam addr_t R_SINV = 6'd30;
  localparam addr_t R_KZ   = 6'd31;
  localparam addr_t R_KV   = 6'd32;
  localparam addr_t R_KA   = 6'd33;

  // load sources (a field of OP_LD)
  localparam addr_t SRC_Z    = 6'd0;
  localparam addr_t SRC_ACC  = 6'd1;
  localparam addr_t SRC_DT   = 6'd2;
  localparam addr_t SRC_QA   = 6'd3;
  localparam addr_t SRC_QB   = 6'd4;
  localparam addr_t SRC_RB   = 6'd5;
  localparam addr_t SRC_ZERO = 6'd6;
  localparam addr_t SRC_ONE  = 6'd7;
  localparam addr_t SRC_BIGP = 6'd8;

  // result lanes (dst field of OP_OUT)
  localparam addr_t LANE_ALT  = 6'd0;
  localparam addr_t LANE_VEL  = 6'd1;
  localparam addr_t LANE_BIAS = 6'd2;

  localparam int PROG_LEN = 108;
  typedef logic [6:0] pc_t;
  localparam pc_t ITEM_PC = 7'd10;

  function automatic instr_t ins(op_t op, addr_t d, addr_t a, addr_t b);
    instr_t r;
    r.op = op; r.seed = 1'b0; r.dst = d; r.a = a; r.b = b;
    return r;
  endfunction

  function automatic instr_t sd(addr_t d, addr_t a);
    instr_t r;
    r.op = OP_LD; r.seed = 1'b1; r.dst = d; r.a = a; r.b = R_ALT;
    return r;
  endfunction

  localparam instr_t PROG [PROG_LEN] = '{
    // covariance init after reset
    ins(OP_LD, R_P0, SRC_ONE, R_ALT),  ins(OP_LD, R_P1, SRC_ZERO, R_ALT),
    ins(OP_LD, R_P2, SRC_ZERO, R_ALT), ins(OP_LD, R_P3, SRC_ZERO, R_ALT),
    ins(OP_LD, R_P4, SRC_ONE, R_ALT),  ins(OP_LD, R_P5, SRC_ZERO, R_ALT),
    ins(OP_LD, R_P6, SRC_ZERO, R_ALT), ins(OP_LD, R_P7, SRC_ZERO, R_ALT),
    ins(OP_LD, R_P8, SRC_BIGP, R_ALT), ins(OP_HALT, R_ALT, R_ALT, R_ALT),
    // item start: operands
    ins(OP_LD, R_Z, SRC_Z, R_ALT),     ins(OP_LD, R_ACC, SRC_ACC, R_ALT),
    ins(OP_LD, R_DT, SRC_DT, R_ALT),   ins(OP_LD, R_QA, SRC_QA, R_ALT),
    ins(OP_LD, R_QB, SRC_QB, R_ALT),   ins(OP_LD, R_RB, SRC_RB, R_ALT),
    // first sample seeds the state
    sd(R_ALT, SRC_Z), sd(R_VEL, SRC_ZERO), sd(R_BIAS, SRC_ZERO),
    // state prediction
    ins(OP_SUB, R_X1, R_ACC, R_BIAS),  ins(OP_MUL, R_X1, R_X1, R_DT),
    ins(OP_ADD, R_VEL, R_VEL, R_X1),   ins(OP_MUL, R_X1, R_VEL, R_DT),
    ins(OP_ADD, R_ALT, R_ALT, R_X1),   ins(OP_MUL, R_DT2, R_DT, R_DT),
    ins(OP_HALF, R_DT2H, R_DT2, R_ALT), ins(OP_MUL, R_DT3H, R_DT2H, R_DT),
    ins(OP_MUL, R_DT4Q, R_DT2H, R_DT2H),
    // T = F * P
    ins(OP_MUL, R_X1, R_DT, R_P3),     ins(OP_ADD, R_T00, R_P0, R_X1),
    ins(OP_MUL, R_X1, R_DT2H, R_P6),   ins(OP_SUB, R_T00, R_T00, R_X1),
    ins(OP_MUL, R_X1, R_DT, R_P4),     ins(OP_ADD, R_T01, R_P1, R_X1),
    ins(OP_MUL, R_X1, R_DT2H, R_P7),   ins(OP_SUB, R_T01, R_T01, R_X1),
    ins(OP_MUL, R_X1, R_DT, R_P5),     ins(OP_ADD, R_T02, R_P2, R_X1),
    ins(OP_MUL, R_X1, R_DT2H, R_P8),   ins(OP_SUB, R_T02, R_T02, R_X1),
    ins(OP_MUL, R_X1, R_DT, R_P6),     ins(OP_SUB, R_T10, R_P3, R_X1),
    ins(OP_MUL, R_X1, R_DT, R_P7),     ins(OP_SUB, R_T11, R_P4, R_X1),
    ins(OP_MUL, R_X1, R_DT, R_P8),     ins(OP_SUB, R_T12, R_P5, R_X1),
    // P = T * F'
    ins(OP_MUL, R_X1, R_DT, R_T01),    ins(OP_ADD, R_P0, R_T00, R_X1),
    ins(OP_MUL, R_X1, R_DT2H, R_T02),  ins(OP_SUB, R_P0, R_P0, R_X1),
    ins(OP_MUL, R_X1, R_DT, R_T02),    ins(OP_SUB, R_P1, R_T01, R_X1),
    ins(OP_MOV, R_P2, R_T02, R_ALT),
    ins(OP_MUL, R_X1, R_DT, R_T11),    ins(OP_ADD, R_P3, R_T10, R_X1),
    ins(OP_MUL, R_X1, R_DT2H, R_T12),  ins(OP_SUB, R_P3, R_P3, R_X1),
    ins(OP_MUL, R_X1, R_DT, R_T12),    ins(OP_SUB, R_P4, R_T11, R_X1),
    ins(OP_MOV, R_P5, R_T12, R_ALT),
    ins(OP_MUL, R_X1, R_DT, R_P7),     ins(OP_ADD, R_P6, R_P6, R_X1),
    ins(OP_MUL, R_X1, R_DT2H, R_P8),   ins(OP_SUB, R_P6, R_P6, R_X1),
    ins(OP_MUL, R_X1, R_DT, R_P8),     ins(OP_SUB, R_P7, R_P7, R_X1),
    // process noise
    ins(OP_MUL, R_X1, R_DT4Q, R_QA),   ins(OP_ADD, R_P0, R_P0, R_X1),
    ins(OP_MUL, R_X1, R_DT3H, R_QA),   ins(OP_ADD, R_P1, R_P1, R_X1),
    ins(OP_ADD, R_P3, R_P3, R_X1),
    ins(OP_MUL, R_X1, R_DT2, R_QA),    ins(OP_ADD, R_P4, R_P4, R_X1),
    ins(OP_ADD, R_P8, R_P8, R_QB),
    // gains
    ins(OP_SUB, R_INNO, R_Z, R_ALT),   ins(OP_ADD, R_X1, R_P0, R_RB),
    ins(OP_RCP, R_SINV, R_X1, R_ALT),
    ins(OP_MUL, R_KZ, R_P0, R_SINV),   ins(OP_MUL, R_KV, R_P3, R_SINV),
    ins(OP_MUL, R_KA, R_P6, R_SINV),
    // state update
    ins(OP_MUL, R_X1, R_KZ, R_INNO),   ins(OP_ADD, R_ALT, R_ALT, R_X1),
    ins(OP_MUL, R_X1, R_KV, R_INNO),   ins(OP_ADD, R_VEL, R_VEL, R_X1),
    ins(OP_MUL, R_X1, R_KA, R_INNO),   ins(OP_ADD, R_BIAS, R_BIAS, R_X1),
    // covariance update, bottom rows first so row 0 is still old
    ins(OP_MUL, R_X1, R_KA, R_P0),     ins(OP_SUB, R_P6, R_P6, R_X1),
    ins(OP_MUL, R_X1, R_KA, R_P1),     ins(OP_SUB, R_P7, R_P7, R_X1),
    ins(OP_MUL, R_X1, R_KA, R_P2),     ins(OP_SUB, R_P8, R_P8, R_X1),
    ins(OP_MUL, R_X1, R_KV, R_P0),     ins(OP_SUB, R_P3, R_P3, R_X1),
    ins(OP_MUL, R_X1, R_KV, R_P1),     ins(OP_SUB, R_P4, R_P4, R_X1),
    ins(OP_MUL, R_X1, R_KV, R_P2),     ins(OP_SUB, R_P5, R_P5, R_X1),
    ins(OP_MUL, R_X1, R_KZ, R_P0),     ins(OP_SUB, R_P0, R_P0, R_X1),
    ins(OP_MUL, R_X1, R_KZ, R_P1),     ins(OP_SUB, R_P1, R_P1, R_X1),
    ins(OP_MUL, R_X1, R_KZ, R_P2),     ins(OP_SUB, R_P2, R_P2, R_X1),
    // results
    ins(OP_OUT, LANE_ALT, R_ALT, R_ALT), ins(OP_OUT, LANE_VEL, R_VEL, R_ALT),
    ins(OP_OUT, LANE_BIAS, R_BIAS, R_ALT), ins(OP_END, R_ALT, R_ALT, R_ALT)
  };

endpackage

`default_nettype wire

// ===== rtl/akf_mul.sv =====
// ----------------------------------------------------------------------------
// akf_mul: shared fixed-point multiplier
// Four 32x32 partial products, then round-to-nearest and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module akf_mul #(
  parameter int SW = 48,
  parameter int FB = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic signed [SW-1:0] a,
  input  wire logic signed [SW-1:0] b,
  output logic                      done,
  output logic signed [SW-1:0]      res
);

  localparam logic [127:0] HALF = 128'(1) << (FB - 1);
  localparam logic [127:0] LIM  = (128'(1) << (SW - 1)) - 128'(1);

  logic         busy;
  logic [2:0]   cnt;
  logic [63:0]  ma, mb;
  logic         neg;
  logic [127:0] acc, rnd;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [1:0]   hsum;

  function automatic logic [SW-1:0] mag(input logic signed [SW-1:0] v);
    return v[SW-1] ? (~v + SW'(1)) : v;
  endfunction

  always_comb begin
    pa   = cnt[0] ? ma[63:32] : ma[31:0];
    pb   = cnt[1] ? mb[63:32] : mb[31:0];
    pp   = pa * pb;
    hsum = {1'b0, cnt[0]} + {1'b0, cnt[1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        ma   <= 64'(mag(a));
        mb   <= 64'(mag(b));
        neg  <= a[SW-1] ^ b[SW-1];
        acc  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt < 3'd4) begin
          acc <= acc + ({64'b0, pp} << {hsum, 5'b0});
        end else if (cnt == 3'd4) begin
          rnd <= (acc + HALF) >> FB;
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
          if (rnd > LIM) res <= neg ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
          else           res <= neg ? -SW'(rnd) : SW'(rnd);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/akf_rcp.sv =====
// ----------------------------------------------------------------------------
// akf_rcp: reciprocal unit
// Restoring division of 2^(2*FB) by a positive value, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module akf_rcp #(
  parameter int SW = 48,
  parameter int FB = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic signed [SW-1:0] s,
  output logic                      done,
  output logic signed [SW-1:0]      res
);

  localparam int IW = $clog2(2 * FB + 1);
  localparam logic [IW-1:0] TOP = IW'(2 * FB);

  logic          busy;
  logic [IW-1:0] i;
  logic [SW-1:0] d, r, q, r2, q_n;
  logic          sat, sat_n, ge, hi;

  always_comb begin
    r2    = {r[SW-2:0], (i == TOP)};
    ge    = (r2 >= d);
    hi    = (int'(i) >= SW - 1);
    q_n   = {q[SW-2:0], ge & ~hi};
    sat_n = sat | (ge & hi);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (s[SW-1] || s == '0) begin
          res  <= '0;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          d    <= s;
          r    <= '0;
          q    <= '0;
          sat  <= 1'b0;
          i    <= TOP;
        end
      end else if (busy) begin
        r   <= ge ? (r2 - d) : r2;
        q   <= q_n;
        sat <= sat_n;
        i   <= i - IW'(1);
        if (i == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
          res  <= sat_n ? {1'b0, {(SW-1){1'b1}}} : q_n;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/akf_dp.sv =====
// ----------------------------------------------------------------------------
// akf_dp: filter datapath
// Register file, saturating adder, format conversions, multiplier, reciprocal.
// ----------------------------------------------------------------------------
`default_nettype none

module akf_dp
  import akf_pkg::*;
#(
  parameter int SW = 48,
  parameter int FB = 24
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire akf_cmd_t  cmd,
  output akf_stat_t      stat,
  input  wire akf_in_t   in_data,
  input  wire logic      cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [31:0] cfg_data,
  output akf_out_t       res
);

  localparam int Q16_SH = FB - 16;
  localparam int Q16_M1 = (Q16_SH > 0) ? Q16_SH - 1 : 0;
  localparam int UP24   = (FB >= 24) ? FB - 24 : 0;
  localparam int DN24   = (FB < 24) ? 24 - FB : 0;
  localparam int DN24M1 = (DN24 > 0) ? DN24 - 1 : 0;
  localparam logic signed [127:0] W_MAX = (128'sd1 <<< (SW - 1)) - 128'sd1;
  localparam logic signed [127:0] W_MIN = -W_MAX - 128'sd1;
  localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

  logic signed [SW-1:0] rf [64];
  logic signed [SW-1:0] rda, rdb, wdata, mul_res, rcp_res;
  logic                 mul_done, rcp_done;
  akf_in_t              in_q;
  logic [31:0]          baro_var, accel_var, bias_var;

  function automatic logic signed [SW-1:0] clampw(input logic signed [127:0] v);
    if (v > W_MAX) return SMAX;
    if (v < W_MIN) return SMIN;
    return SW'(v);
  endfunction

  function automatic logic [SW-1:0] mag(input logic signed [SW-1:0] v);
    return v[SW-1] ? (~v + SW'(1)) : v;
  endfunction

  function automatic logic signed [SW-1:0] from_q16(input logic signed [31:0] x);
    logic signed [127:0] w;
    w = {{96{x[31]}}, x};
    return clampw(w <<< Q16_SH);
  endfunction

  function automatic logic signed [SW-1:0] from_q24u(input logic [31:0] x);
    logic signed [127:0] w;
    w = {96'b0, x};
    if (FB >= 24) return clampw(w <<< UP24);
    return clampw((w >>> DN24) + ((w >>> DN24M1) & 128'sd1));
  endfunction

  function automatic logic signed [SW-1:0] sadd(input logic signed [SW-1:0] x,
                                                input logic signed [SW-1:0] y);
    logic signed [SW:0] t;
    t = {x[SW-1], x} + {y[SW-1], y};
    if (t[SW] != t[SW-1]) return t[SW] ? SMIN : SMAX;
    return t[SW-1:0];
  endfunction

  function automatic logic signed [SW-1:0] ssub(input logic signed [SW-1:0] x,
                                                input logic signed [SW-1:0] y);
    logic signed [SW:0] t;
    t = {x[SW-1], x} - {y[SW-1], y};
    if (t[SW] != t[SW-1]) return t[SW] ? SMIN : SMAX;
    return t[SW-1:0];
  endfunction

  function automatic logic signed [SW-1:0] half(input logic signed [SW-1:0] x);
    logic [SW-1:0] m;
    m = mag(x);
    m = (m >> 1) + SW'(m[0]);
    return x[SW-1] ? -m : m;
  endfunction

  function automatic logic signed [31:0] to_q16(input logic signed [SW-1:0] x);
    logic [127:0]        m;
    logic signed [127:0] v;
    m = 128'(mag(x));
    if (Q16_SH > 0) m = (m >> Q16_SH) + ((m >> Q16_M1) & 128'd1);
    v = x[SW-1] ? -$signed(m) : $signed(m);
    if (v > 128'sd2147483647)  return 32'sh7fffffff;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return 32'(v);
  endfunction

  akf_mul #(.SW(SW), .FB(FB)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.issue && cmd.ins.op == OP_MUL),
    .a     (rda),
    .b     (rdb),
    .done  (mul_done),
    .res   (mul_res)
  );

  akf_rcp #(.SW(SW), .FB(FB)) u_rcp (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.issue && cmd.ins.op == OP_RCP),
    .s     (rda),
    .done  (rcp_done),
    .res   (rcp_res)
  );

  assign stat.unit_done = mul_done | rcp_done;

  always_comb begin
    case (cmd.ins.op)
      OP_LD: begin
        case (cmd.ins.a)
          SRC_Z:    wdata = from_q16(in_q.baro_altitude);
          SRC_ACC:  wdata = from_q16(in_q.vertical_accel);
          SRC_DT:   wdata = from_q24u({8'b0, in_q.time_step});
          SRC_QA:   wdata = from_q24u(accel_var);
          SRC_QB:   wdata = from_q24u(bias_var);
          SRC_RB:   wdata = from_q24u(baro_var);
          SRC_ONE:  wdata = clampw(128'sd1 <<< FB);
          SRC_BIGP: wdata = clampw(128'sd100000 <<< FB);
          default:  wdata = '0;
        endcase
      end
      OP_MOV:  wdata = rda;
      OP_ADD:  wdata = sadd(rda, rdb);
      OP_SUB:  wdata = ssub(rda, rdb);
      OP_HALF: wdata = half(rda);
      OP_MUL:  wdata = mul_res;
      OP_RCP:  wdata = rcp_res;
      default: wdata = rda;
    endcase
  end

  // register file: one write port, two registered read ports
  always_ff @(posedge clk) begin
    rda <= rf[cmd.ins.a];
    rdb <= rf[cmd.ins.b];
    if (cmd.commit && cmd.ins.op != OP_OUT) rf[cmd.ins.dst] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) in_q <= in_data;
    if (cmd.commit && cmd.ins.op == OP_OUT) begin
      case (cmd.ins.dst)
        LANE_ALT:  res.altitude_estimate <= to_q16(rda);
        LANE_VEL:  res.climb_rate        <= to_q16(rda);
        default:   res.accel_bias        <= to_q16(rda);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      baro_var  <= 32'd5872026;
      accel_var <= 32'd33554432;
      bias_var  <= 32'd17;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BARO_NOISE: baro_var  <= cfg_data;
        CFG_ACCEL_VAR:  accel_var <= cfg_data;
        CFG_BIAS_VAR:   bias_var  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/akf_ctrl.sv =====
// ----------------------------------------------------------------------------
// akf_ctrl: filter sequencer
// Steps through the micro-program, one instruction per read/execute pair.
// ----------------------------------------------------------------------------
`default_nettype none

module akf_ctrl
  import akf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire logic      out_free,
  output logic           publish,
  input  wire akf_stat_t stat,
  output akf_cmd_t       cmd
);

  state_t state, state_next;
  pc_t    pc, pc_next;
  logic   first;
  instr_t cur;

  assign cur = PROG[pc];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_READ;
      pc    <= '0;
      first <= 1'b1;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      if (publish) first <= 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    pc_next    = pc;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_READ;
          pc_next    = ITEM_PC;
        end
      end
      ST_READ: begin
        if (cur.seed && !first) pc_next = pc + 7'd1;
        else                    state_next = ST_EXEC;
      end
      ST_EXEC: begin
        case (cur.op)
          OP_MUL, OP_RCP: state_next = ST_WAIT;
          OP_END:         state_next = ST_PUB;
          OP_HALT:        state_next = ST_IDLE;
          default: begin
            state_next = ST_READ;
            pc_next    = pc + 7'd1;
          end
        endcase
      end
      ST_WAIT: begin
        if (stat.unit_done) begin
          state_next = ST_READ;
          pc_next    = pc + 7'd1;
        end
      end
      ST_PUB: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.ins     = cur;
    cmd.issue   = (state == ST_EXEC);
    cmd.in_load = (state == ST_IDLE) && in_valid;
    in_stall    = (state != ST_IDLE);
    publish     = (state == ST_PUB) && out_free;
    case (state)
      ST_EXEC: cmd.commit = (cur.op == OP_LD) || (cur.op == OP_MOV) || (cur.op == OP_ADD) ||
                            (cur.op == OP_SUB) || (cur.op == OP_HALF) || (cur.op == OP_OUT);
      ST_WAIT: cmd.commit = stat.unit_done;
      default: cmd.commit = 1'b0;
    endcase
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    stat.unit_done |-> state == ST_WAIT)
    else $error("unit done outside wait");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_READ && pc == ITEM_PC))
    else $error("accepted item did not start program");

  a_publish_idle: assert property (@(posedge clk) disable iff (rst)
    publish |=> (state == ST_IDLE && !first))
    else $error("publish did not return to idle");

endmodule

`default_nettype wire

// ===== rtl/altitude_kalman_filter_unit.sv =====
// ----------------------------------------------------------------------------
// altitude_kalman_filter_unit: three-state altitude Kalman filter
// Tracks altitude, climb rate and accelerometer bias from baro and accel items.
// ----------------------------------------------------------------------------
//
//  channel  handshake             payload            direction
//  in       in_valid / in_stall   akf_in_t in_data   into block
//  out      out_valid / out_stall akf_out_t out_data out of block
//  cfg      cfg_valid / cfg_ready cfg_index,cfg_data into block
//
// Each item runs its micro-ops in order, each as a read step and an execute step:
// 95 micro-ops, plus the three seed micro-ops on the first item only. Each of the
// 41 products also waits on the shared 32x32 multiplier, the reciprocal on the
// one-bit-a-cycle divider, and the three seed ops are skipped on later items;
// the accept and the publish each take a state of their own.
// After reset a pass loads the covariance; in_stall is high until then.
// One item is in work at a time; a finished item waits in the output register
// while the next one is accepted and computed.
// Config writes are always ready and must be made while the block is idle.
//
`default_nettype none

module altitude_kalman_filter_unit
  import akf_pkg::*;
#(
  parameter int STATE_WIDTH = 48,
  parameter int FRAC_BITS   = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire akf_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output akf_out_t         out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  akf_cmd_t  cmd;
  akf_stat_t stat;
  akf_out_t  res;
  logic      publish;
  logic      out_free;

  assign cfg_ready = 1'b1;
  // output slot can take a new item if empty or emptying this cycle
  assign out_free  = !out_valid || !out_stall;

  akf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_free (out_free),
    .publish  (publish),
    .stat     (stat),
    .cmd      (cmd)
  );

  akf_dp #(.SW(STATE_WIDTH), .FB(FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (publish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (publish) out_data <= res;
  end

endmodule

`default_nettype wire
